@@ hdl/mqpf_pkg.sv @@
// Shared types and constants for the multi-queue priority FIFO.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mqpf_pkg;

  localparam int LEVELS   = 5;
  localparam int OP_W     = 1;
  localparam int QN_W     = 6;
  localparam int LVL_W    = 3;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 4;

  localparam logic [OP_W-1:0] OP_ENTER = 1'b0;
  localparam logic [OP_W-1:0] OP_LEAVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ENTERED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEPARTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_QUEUE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic [CFG_W-1:0] QUEUES_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic load_item;
    logic read_row;
    logic decide;
    logic take_tag;
  } mqpf_cmd_t;

  typedef struct packed {
    logic need_tag;
  } mqpf_sts_t;

endpackage

`default_nettype wire

@@ hdl/mqpf_if.sv @@
// Channel interfaces: request input, result output and configuration write.
// Depends on mqpf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mqpf_in_if import mqpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [QN_W-1:0]  queue_number;
  logic [LVL_W-1:0] level;
  logic [TAG_W-1:0] customer_tag;

  modport source (output valid, op, queue_number, level, customer_tag, input ready);
  modport sink   (input valid, op, queue_number, level, customer_tag, output ready);
endinterface

interface mqpf_out_if import mqpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    departed_tag;
  logic [LVL_W-1:0]    departed_level;

  modport source (output valid, status, departed_tag, departed_level, input ready);
  modport sink   (input valid, status, departed_tag, departed_level, output ready);
endinterface

interface mqpf_cfg_if import mqpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/mqpf_ctrl.sv @@
// Sequencer for one request: load, row read, decide, optional tag read, result.
// Depends on mqpf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mqpf_ctrl import mqpf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output mqpf_cmd_t      cmd,
  input  wire mqpf_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ROW    = 5'b00010,
    S_DECIDE = 5'b00100,
    S_TAG    = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_ROW;
      S_ROW:    state_next = S_DECIDE;
      S_DECIDE: state_next = sts.need_tag ? S_TAG : S_OUT;
      S_TAG:    state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready      = (state == S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign cmd.load_item = (state == S_IDLE) && in_valid;
  assign cmd.read_row  = (state == S_ROW);
  assign cmd.decide    = (state == S_DECIDE);
  assign cmd.take_tag  = (state == S_TAG);

  a_load_then_row: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> cmd.read_row)
    else $error("row read did not follow item load");

  a_hit_then_tag: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && sts.need_tag |=> cmd.take_tag)
    else $error("tag capture did not follow a departing hit");

  a_out_then_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not ready for input after result transfer");

endmodule

`default_nettype wire

@@ hdl/mqpf_datapath.sv @@
// Queue state, tag memory, priority select and result registers.
// Depends on mqpf_pkg; driven by commands from mqpf_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mqpf_datapath import mqpf_pkg::*; #(
  parameter int QUEUES     = 8,
  parameter int RING_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mqpf_cmd_t           cmd,
  output mqpf_sts_t                sts,
  input  wire logic                cfg_valid,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [QN_W-1:0]     in_queue_number,
  input  wire logic [LVL_W-1:0]    in_level,
  input  wire logic [TAG_W-1:0]    in_customer_tag,
  output logic [STATUS_W-1:0]      out_status,
  output logic [TAG_W-1:0]         out_tag,
  output logic [LVL_W-1:0]         out_level
);

  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int SLOTS = QUEUES * LEVELS * RING_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int HW    = $clog2(RING_DEPTH);
  localparam int SW    = CW + 1;
  localparam logic [6:0] QUEUES_7 = 7'(QUEUES);

  logic [CFG_W-1:0] queues_in_use;

  logic [OP_W-1:0]  op_q;
  logic [QN_W-1:0]  qn_q;
  logic [LVL_W-1:0] lvl_q;
  logic [TAG_W-1:0] tag_q;

  logic [LEVELS-1:0][CW-1:0] cnt_mem  [QUEUES];
  logic [LEVELS-1:0][HW-1:0] head_mem [QUEUES];
  logic [QUEUES-1:0]         row_valid;
  logic [LEVELS-1:0][CW-1:0] row_cnt;
  logic [LEVELS-1:0][HW-1:0] row_head;
  logic                      row_ok;

  logic [TAG_W-1:0] tag_mem [SLOTS];
  logic [TAG_W-1:0] tag_rd;

  logic [QN_W-1:0]           qn_m1;
  logic [QW-1:0]             qidx;
  logic [6:0]                qlimit;
  logic                      bad;
  logic [LVL_W-1:0]          lvl_eff;
  logic [LEVELS-1:0][CW-1:0] cnt_eff;
  logic [LEVELS-1:0][HW-1:0] head_eff;
  logic [CW-1:0]             cnt_sel;
  logic [HW-1:0]             head_sel;
  logic                      full;
  logic [SW-1:0]             wr_sum;
  logic [SW-1:0]             wr_wrap;
  logic                      found;
  logic [LVL_W-1:0]          hit_lvl;
  logic [HW-1:0]             rd_head;
  logic [HW-1:0]             head_inc;
  logic [LEVELS-1:0][CW-1:0] cnt_new;
  logic [LEVELS-1:0][HW-1:0] head_new;
  logic [LVL_W-1:0]          sel_lvl;
  logic [HW-1:0]             sel_slot;
  logic [AW-1:0]             ring_w;
  logic [AW-1:0]             tag_addr;
  logic                      row_we;
  logic                      tag_we;
  logic                      tag_re;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= QUEUES_IN_USE_RST;
    end else if (cfg_valid) begin
      queues_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= in_op;
      qn_q  <= in_queue_number;
      lvl_q <= in_level;
      tag_q <= in_customer_tag;
    end
  end

  assign qn_m1  = qn_q - 6'd1;
  assign qidx   = qn_m1[QW-1:0];
  assign qlimit = ({3'b000, queues_in_use} > QUEUES_7) ? QUEUES_7 : {3'b000, queues_in_use};
  assign bad    = (qn_q == '0) || ({1'b0, qn_q} > qlimit);

  // Row memory: counts and heads of the five rings of one queue.
  always_ff @(posedge clk) begin
    if (cmd.read_row) begin
      row_cnt  <= cnt_mem[qidx];
      row_head <= head_mem[qidx];
    end
    if (row_we) begin
      cnt_mem[qidx]  <= cnt_new;
      head_mem[qidx] <= head_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_ok    <= 1'b0;
    end else begin
      if (cmd.read_row) row_ok <= row_valid[qidx];
      if (row_we) row_valid[qidx] <= 1'b1;
    end
  end

  assign cnt_eff  = row_ok ? row_cnt : '0;
  assign head_eff = row_ok ? row_head : '0;
  assign lvl_eff  = (lvl_q >= LVL_W'(LEVELS)) ? '0 : lvl_q;
  assign cnt_sel  = cnt_eff[lvl_eff];
  assign head_sel = head_eff[lvl_eff];
  assign full     = (cnt_sel == CW'(RING_DEPTH));
  assign wr_sum   = SW'(head_sel) + SW'(cnt_sel);
  assign wr_wrap  = (wr_sum >= SW'(RING_DEPTH)) ? wr_sum - SW'(RING_DEPTH) : wr_sum;

  // Highest non-empty level wins.
  always_comb begin
    found   = 1'b0;
    hit_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_eff[l] != '0) begin
        found   = 1'b1;
        hit_lvl = LVL_W'(l);
      end
    end
  end

  assign rd_head  = head_eff[hit_lvl];
  assign head_inc = (rd_head == HW'(RING_DEPTH - 1)) ? '0 : rd_head + 1'b1;

  always_comb begin
    cnt_new  = cnt_eff;
    head_new = head_eff;
    if (op_q == OP_LEAVE) begin
      cnt_new[hit_lvl]  = cnt_eff[hit_lvl] - 1'b1;
      head_new[hit_lvl] = head_inc;
    end else begin
      cnt_new[lvl_eff] = cnt_sel + 1'b1;
    end
  end

  assign sel_lvl  = (op_q == OP_LEAVE) ? hit_lvl : lvl_eff;
  assign sel_slot = (op_q == OP_LEAVE) ? rd_head : wr_wrap[HW-1:0];
  assign ring_w   = AW'(qidx) * AW'(LEVELS) + AW'(sel_lvl);
  assign tag_addr = ring_w * AW'(RING_DEPTH) + AW'(sel_slot);

  assign tag_we = cmd.decide && !bad && (op_q == OP_ENTER) && !full;
  assign tag_re = cmd.decide && !bad && (op_q == OP_LEAVE) && found;
  assign row_we = tag_we || tag_re;
  assign sts.need_tag = tag_re;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_addr] <= tag_q;
    if (tag_re) tag_rd <= tag_mem[tag_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_tag   <= '0;
      out_level <= '0;
      priority if (bad) begin
        out_status <= ST_BAD_QUEUE;
      end else if (op_q == OP_ENTER) begin
        out_status <= full ? ST_FULL : ST_ENTERED;
      end else if (found) begin
        out_status <= ST_DEPARTED;
        out_level  <= hit_lvl;
      end else begin
        out_status <= ST_EMPTY;
      end
    end else if (cmd.take_tag) begin
      out_tag <= tag_rd;
    end
  end

  a_enter_marks_row: assert property (@(posedge clk) disable iff (rst)
    tag_we |=> row_valid[$past(qidx)])
    else $error("row not marked valid after enter");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    tag_we |-> cnt_sel < CW'(RING_DEPTH))
    else $error("enter into a full ring");

  a_leave_nonempty: assert property (@(posedge clk) disable iff (rst)
    tag_re |-> cnt_eff[hit_lvl] != '0 && sel_lvl == hit_lvl)
    else $error("departure from an empty ring");

endmodule

`default_nettype wire

@@ hdl/multi_queue_priority_fifo.sv @@
// Multi-queue strict-priority FIFO: queues numbered 1..queues_in_use (capped
// at QUEUES), each with five priority levels of FIFO rings of RING_DEPTH tags.
// Channels: in_ch carries enter (op 0) and leave (op 1) requests; out_ch returns
// exactly one result per request (status, departed tag and level); cfg writes
// queues_in_use, always ready, and must only be written while the block is idle.
// Timing: one request at a time. A request gives its result after the states
// row read and decide (enter, bad queue, empty) or row read, decide and tag
// (departure, which adds a tag memory read). The sequence is row memory read,
// decision with row and tag memory write, optional tag read. The next request
// is taken the cycle after the result transfers; none is taken before that.
// Stall: a waiting result holds on out_ch and no request is taken meanwhile.
// Reset (rst, synchronous): all queues empty at once through per-queue valid
// bits, queues_in_use back to 8, no result pending. Depends on mqpf_pkg,
// mqpf_if, mqpf_ctrl and mqpf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_priority_fifo import mqpf_pkg::*; #(
  parameter int QUEUES     = 8,
  parameter int RING_DEPTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  mqpf_in_if.sink    in_ch,
  mqpf_out_if.source out_ch,
  mqpf_cfg_if.sink   cfg
);

  mqpf_cmd_t cmd;
  mqpf_sts_t sts;

  assign cfg.ready = 1'b1;

  mqpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mqpf_datapath #(
    .QUEUES     (QUEUES),
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg.valid),
    .cfg_data        (cfg.data),
    .in_op           (in_ch.op),
    .in_queue_number (in_ch.queue_number),
    .in_level        (in_ch.level),
    .in_customer_tag (in_ch.customer_tag),
    .out_status      (out_ch.status),
    .out_tag         (out_ch.departed_tag),
    .out_level       (out_ch.departed_level)
  );

endmodule

`default_nettype wire
